@@ design/bone_weight_compact_normalize_defines.svh @@
// Shared assertion macros for the bone weight block.
`ifndef BONE_WEIGHT_COMPACT_NORMALIZE_DEFINES_SVH
`define BONE_WEIGHT_COMPACT_NORMALIZE_DEFINES_SVH

// same-cycle implication
`define BWCN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BWCN_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/bwcn_pkg.sv @@
package bwcn_pkg;

   localparam int SLOTS           = 4;
   localparam int SLOT_W          = $clog2(SLOTS);
   localparam int IDX_W           = 16;
   localparam int WGT_IN_W        = 16;
   localparam int WGT_W           = 15;
   localparam int SUM_W           = 17;
   localparam int DIV_REM_W       = SUM_W + 1;
   localparam int DIV_STEPS       = WGT_W;
   localparam int TDATA_W         = 128;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [SUM_W-1:0] Q_ONE     = SUM_W'(16384);
   localparam logic [IDX_W-1:0] IDX_EMPTY = '1;

   // compacted vertex as it leaves the front end
   typedef struct packed {
      logic [SLOTS-1:0][IDX_W-1:0] idx;
      logic [SLOTS-1:0][WGT_W-1:0] wgt;
      logic [SUM_W-1:0]            sum;
      logic                        norm;
   } vertex_type;

   // one stage of the restoring divider pipeline
   typedef struct packed {
      logic                            valid;
      logic [SLOTS-1:0][IDX_W-1:0]     idx;
      logic [SLOTS-1:0][WGT_W-1:0]     raw;
      logic [SUM_W-1:0]                sum;
      logic                            norm;
      logic [SLOTS-1:0][DIV_REM_W-1:0] rem;
      logic [SLOTS-1:0][WGT_W-1:0]     quo;
   } div_stage_type;

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [DIV_REM_W:0] div_step(input logic [DIV_REM_W-1:0] rem,
                                                   input logic [SUM_W-1:0] dvs);
      logic [DIV_REM_W-1:0] d;
      d = DIV_REM_W'(dvs);
      if (rem >= d) begin
         return {1'b1, rem - d};
      end else begin
         return {1'b0, rem};
      end
   endfunction

endpackage

@@ design/bone_weight_compact_normalize.sv @@
// Channel   Dir  Handshake              Payload
// request   in   req_tvalid/req_tready  req_tdata: 4 bone indices, 4 Q1.14 weights
// response  out  rsp_tvalid/rsp_tready  rsp_tdata: 4 packed indices, 4 scaled weights
//
// Sustains one request per cycle while no response stalls: the queue entry is written when
// the request is accepted, then the 15 divider stages, one quotient bit each over four
// lanes, load in turn.
// Reset clears the queue pointers and the divider valid bits.
// A stalled response freezes the divider; the queue keeps taking requests until
// it holds QUEUE_DEPTH of them, then req_tready drops.
module bone_weight_compact_normalize
   import bwcn_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // in_index_0..3 [63:0] 16b each, in_weight_0..3 [127:64] 16b each
   input  logic [TDATA_W-1:0] req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // out_index_0..3 [63:0] 16b each, out_weight_0..3 [123:64] 15b each, [127:124] zero
   output logic [TDATA_W-1:0] rsp_tdata
);

   vertex_type    front_vtx;
   vertex_type    head_vtx;
   logic          head_valid;
   logic          head_ready;
   div_stage_type last_stage;

   bwcn_front u_front (
      .req_data (req_tdata),
      .vtx      (front_vtx)
   );

   bwcn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (front_vtx),
      .out_valid (head_valid),
      .out_ready (head_ready),
      .out_data  (head_vtx)
   );

   bwcn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (head_valid),
      .in_ready  (head_ready),
      .in_data   (head_vtx),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_stage (last_stage)
   );

   always_comb begin
      rsp_tdata = '0;
      for (int l = 0; l < SLOTS; l++) begin
         rsp_tdata[IDX_W*l +: IDX_W] = last_stage.idx[l];
         rsp_tdata[IDX_W*SLOTS + WGT_W*l +: WGT_W] =
            last_stage.norm ? last_stage.quo[l] : last_stage.raw[l];
      end
   end

endmodule

@@ design/bwcn_front.sv @@
module bwcn_front
   import bwcn_pkg::*;
(
   input  logic [TDATA_W-1:0] req_data,
   output vertex_type         vtx
);

   always_comb begin
      logic [IDX_W-1:0]    idx_i;
      logic [WGT_IN_W-1:0] w_i;
      logic [SLOT_W-1:0]   cnt;
      logic [SUM_W-1:0]    sum;
      cnt = '0;
      sum = '0;
      for (int i = 0; i < SLOTS; i++) begin
         vtx.idx[i] = IDX_EMPTY;
         vtx.wgt[i] = '0;
      end
      for (int i = 0; i < SLOTS; i++) begin
         idx_i = req_data[IDX_W*i +: IDX_W];
         w_i   = req_data[IDX_W*SLOTS + WGT_IN_W*i +: WGT_IN_W];
         // keep only non-negative index with strictly positive weight
         if (!idx_i[IDX_W-1] && !w_i[WGT_IN_W-1] && (w_i != '0)) begin
            vtx.idx[cnt] = idx_i;
            vtx.wgt[cnt] = w_i[WGT_W-1:0];
            sum = sum + SUM_W'(w_i[WGT_W-1:0]);
            cnt = cnt + 1'b1;
         end
      end
      vtx.sum  = sum;
      vtx.norm = (sum != '0) && (sum != Q_ONE);
   end

endmodule

@@ design/bwcn_queue.sv @@
module bwcn_queue
   import bwcn_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  vertex_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output vertex_type out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   vertex_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ design/bwcn_div.sv @@
module bwcn_div
   import bwcn_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  vertex_type    in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output div_stage_type out_stage
);

   localparam int LAST = DIV_STEPS - 1;

   div_stage_type s_ff [DIV_STEPS];
   div_stage_type s_in [DIV_STEPS];
   logic          en;

   // whole pipeline moves unless the final stage holds a stalled request
   assign en        = !s_ff[LAST].valid || out_ready;
   assign in_ready  = en;
   assign out_valid = s_ff[LAST].valid;
   assign out_stage = s_ff[LAST];

   // first step yields the top quotient bit (set only when w equals the sum)
   always_comb begin
      logic [DIV_REM_W:0] st;
      s_in[0].valid = in_valid;
      s_in[0].idx   = in_data.idx;
      s_in[0].raw   = in_data.wgt;
      s_in[0].sum   = in_data.sum;
      s_in[0].norm  = in_data.norm;
      for (int l = 0; l < SLOTS; l++) begin
         st = div_step(DIV_REM_W'(in_data.wgt[l]), in_data.sum);
         s_in[0].rem[l]           = st[DIV_REM_W-1:0];
         s_in[0].quo[l]           = '0;
         s_in[0].quo[l][LAST]     = st[DIV_REM_W];
      end
   end

   for (genvar k = 1; k < DIV_STEPS; k++) begin : g_step
      always_comb begin
         logic [DIV_REM_W:0] st;
         s_in[k] = s_ff[k-1];
         for (int l = 0; l < SLOTS; l++) begin
            st = div_step({s_ff[k-1].rem[l][DIV_REM_W-2:0], 1'b0}, s_ff[k-1].sum);
            s_in[k].rem[l]          = st[DIV_REM_W-1:0];
            s_in[k].quo[l][LAST-k]  = st[DIV_REM_W];
         end
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            s_ff[k].valid <= 1'b0;
         end else if (en) begin
            s_ff[k] <= s_in[k];
         end
      end
   end

endmodule

@@ design/bwcn_checker.sv @@
`include "bone_weight_compact_normalize_defines.svh"

module bwcn_checker
   import bwcn_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [TDATA_W-1:0] rsp_tdata
);

   localparam int PAY_W = IDX_W*SLOTS + WGT_W*SLOTS;

   logic                     rsp_stall;
   logic [TDATA_W-PAY_W-1:0] rsp_pad;
   logic [SLOTS-1:0]         vacant;
   logic [SLOTS-1:0]         weight_ok;
   logic                     order_ok;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_pad   = rsp_tdata[TDATA_W-1:PAY_W];

   always_comb begin
      for (int l = 0; l < SLOTS; l++) begin
         vacant[l]    = (rsp_tdata[IDX_W*l +: IDX_W] == IDX_EMPTY);
         weight_ok[l] = !vacant[l] || (rsp_tdata[IDX_W*SLOTS + WGT_W*l +: WGT_W] == '0);
      end
   end

   // compaction: an empty slot is followed only by empty slots
   assign order_ok = &(~vacant[SLOTS-2:0] | vacant[SLOTS-1:1]);

   `BWCN_ASSERT_NXT(a_hold_vld, clock, reset, rsp_stall, rsp_tvalid, "stalled response dropped")

   `BWCN_ASSERT_NXT(a_hold_data, clock, reset, rsp_stall, $stable(rsp_tdata), "response not held")

   `BWCN_ASSERT_IMP(a_rsp_pad, clock, reset, rsp_tvalid, rsp_pad == '0, "pad bits not zero")

   `BWCN_ASSERT_IMP(a_compact, clock, reset, rsp_tvalid, order_ok, "kept slot after empty slot")

   `BWCN_ASSERT_IMP(a_empty_wgt, clock, reset, rsp_tvalid, &weight_ok, "empty slot with weight")

endmodule

bind bone_weight_compact_normalize bwcn_checker u_bwcn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/sv/tb_bone_weight_compact_normalize.sv @@
module tb_bone_weight_compact_normalize;
   import bwcn_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 50;
   localparam int PHASE_ITEMS    = 180;
   localparam int PRESSURE_ITEMS = 40;
   localparam int MAX_PRINTS     = 40;

   // request payload, lowest field first: idx[0..3], then wgt[0..3]
   typedef struct packed {
      logic [SLOTS-1:0][WGT_IN_W-1:0] wgt;
      logic [SLOTS-1:0][IDX_W-1:0]    idx;
   } raw_vertex_type;

   // response payload, lowest field first: idx[0..3], wgt[0..3], zero pad
   typedef struct packed {
      logic [3:0]                  pad;
      logic [SLOTS-1:0][WGT_W-1:0] wgt;
      logic [SLOTS-1:0][IDX_W-1:0] idx;
   } packed_vertex_type;

   typedef enum {GEN_NOISE, GEN_MIXED, GEN_UNIT_SUM, GEN_TINY, GEN_EDGE} gen_kind_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;

   packed_vertex_type pending_vertices[$];
   int                sender_gap_pct = 0;
   int                receiver_stall_pct = 0;
   int                hold_requests = 0;
   int                holds_served = 0;
   int                hold_left = 0;
   int                quiet_cycles = 0;
   int                vertices_sent = 0;
   int                directed_sent = 0;
   int                results_checked = 0;
   int                mismatch_count = 0;

   bone_weight_compact_normalize i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // keep valid pairs in order, pad with empty slots, rescale unless the sum is zero or one
   function automatic packed_vertex_type normalize_vertex(raw_vertex_type v);
      packed_vertex_type           r;
      logic [SLOTS-1:0][WGT_W-1:0] kept_wgt;
      logic [SUM_W-1:0]            total;
      logic [31:0]                 scaled;
      int                          kept;
      r.pad    = '0;
      r.idx    = {SLOTS{IDX_EMPTY}};
      kept_wgt = '0;
      total    = '0;
      kept     = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if ($signed(v.idx[i]) >= 0 && $signed(v.wgt[i]) > 0) begin
            r.idx[kept]      = v.idx[i];
            kept_wgt[kept]   = v.wgt[i][WGT_W-1:0];
            total            = total + SUM_W'(v.wgt[i][WGT_W-1:0]);
            kept++;
         end
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (total != '0 && total != Q_ONE) begin
            scaled   = (32'(kept_wgt[i]) << 14) / 32'(total);
            r.wgt[i] = scaled[WGT_W-1:0];
         end else begin
            r.wgt[i] = kept_wgt[i];
         end
      end
      return r;
   endfunction

   function automatic raw_vertex_type make_vertex(input int i0, i1, i2, i3, w0, w1, w2, w3);
      raw_vertex_type v;
      v.idx = {16'(i3), 16'(i2), 16'(i1), 16'(i0)};
      v.wgt = {16'(w3), 16'(w2), 16'(w1), 16'(w0)};
      return v;
   endfunction

   function automatic raw_vertex_type random_vertex();
      raw_vertex_type v;
      gen_kind_type   kind;
      int unsigned    pick;
      int unsigned    mask;
      int unsigned    n_keep;
      int unsigned    placed;
      int unsigned    remaining;
      int unsigned    part;
      v    = {$urandom, $urandom, $urandom, $urandom};
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1:    kind = GEN_NOISE;
         6, 7:    kind = GEN_UNIT_SUM;
         8:       kind = GEN_TINY;
         9:       kind = GEN_EDGE;
         default: kind = GEN_MIXED;
      endcase
      if (kind == GEN_NOISE) begin
         return v;
      end
      mask      = (kind == GEN_UNIT_SUM) ? $urandom_range(1, 15)
                                         : ($urandom_range(0, 15) | $urandom_range(0, 15));
      n_keep    = $countones(mask);
      placed    = 0;
      remaining = 16384;
      for (int i = 0; i < SLOTS; i++) begin
         if (!mask[i]) begin
            // dropped pair: either a negative index or a non-positive weight
            if ($urandom_range(0, 1)) begin
               v.idx[i] = 16'($urandom_range(32768, 65535));
            end else begin
               v.wgt[i] = $urandom_range(0, 1) ? 16'h0 : 16'($urandom_range(32768, 65535));
            end
         end else begin
            v.idx[i] = (kind == GEN_EDGE) ? ($urandom_range(0, 1) ? 16'h7FFF : 16'h0)
                                          : 16'($urandom_range(0, 32767));
            case (kind)
               GEN_UNIT_SUM: begin
                  if (placed == n_keep - 1) begin
                     part = remaining;
                  end else begin
                     part = $urandom_range(1, remaining - (n_keep - 1 - placed));
                  end
                  remaining = remaining - part;
                  placed++;
                  v.wgt[i] = 16'(part);
               end
               GEN_TINY: begin
                  v.wgt[i] = 16'($urandom_range(1, 8));
               end
               GEN_EDGE: begin
                  case ($urandom_range(0, 4))
                     0:       v.wgt[i] = 16'd1;
                     1:       v.wgt[i] = 16'd16383;
                     2:       v.wgt[i] = 16'd16384;
                     3:       v.wgt[i] = 16'd16385;
                     default: v.wgt[i] = 16'd32767;
                  endcase
               end
               default: begin
                  v.wgt[i] = 16'($urandom_range(1, 32767));
               end
            endcase
         end
      end
      return v;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      if (mismatch_count < MAX_PRINTS) begin
         $display("mismatch @%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
      end
      mismatch_count++;
   endtask

   task automatic send_vertex(input raw_vertex_type v);
      while ($urandom_range(0, 99) < sender_gap_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom, $urandom, $urandom};
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      pending_vertices.push_back(normalize_vertex(v));
      vertices_sent++;
   endtask

   // receiver: long hold-off when requested, otherwise random stalls
   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left    <= HOLD_CYCLES - 1;
         rsp_tready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : check_response
      packed_vertex_type got;
      packed_vertex_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_vertices.size() == 0) begin
            report_mismatch("response with no request pending", 0, got.idx[0]);
         end else begin
            want = pending_vertices.pop_front();
            for (int i = 0; i < SLOTS; i++) begin
               if (got.idx[i] !== want.idx[i]) begin
                  report_mismatch($sformatf("index slot %0d", i), want.idx[i], got.idx[i]);
               end
               if (got.wgt[i] !== want.wgt[i]) begin
                  report_mismatch($sformatf("weight slot %0d", i), want.wgt[i], got.wgt[i]);
               end
            end
            if (got.pad !== want.pad) begin
               report_mismatch("pad bits", want.pad, got.pad);
            end
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("[bone_weight_compact_normalize] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_directed();
      raw_vertex_type list[$];
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      list.push_back(make_vertex(1, 2, 3, 4, 4096, 4096, 4096, 4096));       // sum is one
      list.push_back(make_vertex(-1, -1, -1, -1, 1000, 2000, 3000, 4000));   // nothing kept
      list.push_back(make_vertex(0, 5, 6, 7, 0, 0, 0, 0));                   // zero weights
      list.push_back(make_vertex(0, 1, 2, 3, -1, -32768, -100, -16384));    // negative weights
      list.push_back(make_vertex(-32768, 10, -2, 20, 32767, 300, 32767, 700));
      list.push_back(make_vertex(32767, 32767, 32767, 32767,
                                 32767, 32767, 32767, 32767));               // max sum
      list.push_back(make_vertex(-1, 3, -1, -1, 5, 1, 5, 5));                 // lone tiny weight
      list.push_back(make_vertex(9, -1, -1, -1, 32767, 1, 1, 1));             // lone max weight
      list.push_back(make_vertex(-1, -1, 12, -1, 7, 7, 16384, 7));            // lone unit weight
      list.push_back(make_vertex(-5, 7, 9, 11, 100, 300, 0, 500));            // compaction
      list.push_back(make_vertex(0, 0, 0, -1, 1, 1, 1, 1));
      list.push_back(make_vertex(4, 8, -1, -1, 16383, 1, 9, 9));              // split unit sum
      list.push_back(make_vertex(4, 8, -1, -1, 16383, 2, 9, 9));              // just over one
      list.push_back(make_vertex(-1, -1, -1, 32767, 9, 9, 9, 123));           // last slot only
      list.push_back(make_vertex(1, 2, 3, 4, 1, 2, 3, 32767));
      list.push_back(make_vertex(-1, 0, 6, -7, -1, 0, 8000, 0));
      list.push_back(make_vertex(32767, 1, 2, 3, 1, 0, 0, 0));
      list.push_back(make_vertex(32767, 32767, 32767, 32767,
                                 -32768, -32768, -32768, -32768));
      list.push_back(make_vertex(0, 0, 0, 0, 0, 0, 0, 0));
      list.push_back(make_vertex(-1, -1, -1, -1, -1, -1, -1, -1));
      foreach (list[k]) begin
         send_vertex(list[k]);
      end
      directed_sent = list.size();
   endtask

   task automatic run_random_phase(input int items, input int gap_pct, input int stall_pct);
      sender_gap_pct     = gap_pct;
      receiver_stall_pct = stall_pct;
      repeat (items) begin
         send_vertex(random_vertex());
      end
   endtask

   task automatic test_random_streaming();
      run_random_phase(PHASE_ITEMS, 0, 0);
      run_random_phase(PHASE_ITEMS, 67, 0);
      run_random_phase(PHASE_ITEMS, 0, 67);
      run_random_phase(PHASE_ITEMS, 11, 11);
   endtask

   // receiver holds off while requests keep coming, so the block must fill and push back
   task automatic test_output_hold();
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      hold_requests++;
      repeat (PRESSURE_ITEMS) begin
         send_vertex(random_vertex());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_streaming();
      test_output_hold();
      req_tvalid         <= 1'b0;
      receiver_stall_pct = 0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run: %0d vertices (%0d directed), %0d responses checked, %0d mismatches",
               vertices_sent, directed_sent, results_checked, mismatch_count);
      $display("idle/stall mixes 0/0, 67/0, 0/67, 11/11 plus a %0d-cycle output hold",
               HOLD_CYCLES);
      if (mismatch_count == 0 && pending_vertices.size() == 0) begin
         $display("[bone_weight_compact_normalize] OK");
      end else begin
         $display("[bone_weight_compact_normalize] ERROR");
      end
      $finish;
   end

endmodule
